// File: hw/rtl/gbu_pkg.sv
// Shared types and constants of the grid byte unpacker.
package gbu_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_FROM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_TO     = 3'd4;

	// Pack modes (code 3 behaves as pass through)
	localparam logic [1:0] MODE_PASS    = 2'd0;
	localparam logic [1:0] MODE_INVERT  = 2'd1;
	localparam logic [1:0] MODE_REVERSE = 2'd2;

	// Command kinds handed from front to back
	localparam logic [1:0] KIND_PASS = 2'd0;  // single byte, already unpacked
	localparam logic [1:0] KIND_REV  = 2'd1;  // full run: reversed, inverted
	localparam logic [1:0] KIND_FWD  = 2'd2;  // partial run at grid end: as stored

	// Run store address width at the largest supported run
	localparam int STORE_ADDR_W = 6;

	// Command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic [1:0] pack_mode;
		logic [6:0] run_length;
		logic       fold_enable;
		logic [7:0] fold_from;
		logic [7:0] fold_to;
	} gbu_cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [6:0] count;
		logic       last_grid;
	} gbu_cmd_t;

	typedef struct packed {
		logic                    en;
		logic [STORE_ADDR_W-1:0] addr;
		logic [7:0]              data;
	} gbu_wr_t;

endpackage

// File: hw/rtl/gbu_queue.sv
// Short command queue between the front and the back of the unpacker.
module gbu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gbu_pkg::gbu_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output gbu_pkg::gbu_cmd_t head,
	output logic              head_valid
);
	import gbu_pkg::*;

	gbu_cmd_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && head_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/gbu_front.sv
// Front of the unpacker: accepts bytes, fills the run store, issues commands.
module gbu_front #(
	parameter int MAX_RUN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbu_pkg::gbu_cfg_t cfg,
	input  logic              cfg_clear,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_end,
	output logic              q_push,
	output gbu_pkg::gbu_cmd_t q_cmd,
	input  logic              q_full,
	output gbu_pkg::gbu_wr_t  wr,
	input  logic              run_done
);
	import gbu_pkg::*;

	localparam logic [6:0] MaxLen = 7'(MAX_RUN);

	logic [6:0] fill_q;
	logic       busy_q;
	logic [6:0] len;
	logic       run_mode;
	logic       accept;
	logic [6:0] fill_inc;
	logic       run_full;

	// Effective run length and mode classification
	assign len      = (cfg.run_length > MaxLen) ? MaxLen : cfg.run_length;
	assign run_mode = (cfg.pack_mode == MODE_REVERSE) && (len != '0);

	// Hold input while the queue is full or while the back drains the store
	assign in_ready = !q_full && !(run_mode && busy_q);
	assign accept   = in_valid && in_ready;
	assign fill_inc = fill_q + 7'd1;
	assign run_full = (fill_inc == len);

	// Store write
	assign wr.en   = accept && run_mode;
	assign wr.addr = fill_q[STORE_ADDR_W-1:0];
	assign wr.data = in_byte;

	// Command build
	always_comb begin
		q_cmd.last_grid = in_end;
		if (run_mode) begin
			q_push      = accept && (run_full || in_end);
			q_cmd.kind  = run_full ? KIND_REV : KIND_FWD;
			q_cmd.data  = in_byte;
			q_cmd.count = fill_inc;
		end else begin
			q_push      = accept;
			q_cmd.kind  = KIND_PASS;
			q_cmd.data  = (cfg.pack_mode == MODE_INVERT) ? ~in_byte : in_byte;
			q_cmd.count = 7'd1;
		end
	end

	// Fill count and store ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (cfg_clear) begin
				fill_q <= '0;
			end else if (accept && run_mode) begin
				fill_q <= (run_full || in_end) ? 7'd0 : fill_inc;
			end
			if (run_done) begin
				busy_q <= 1'b0;
			end else if (q_push && run_mode) begin
				busy_q <= 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/gbu_back.sv
// Back of the unpacker: run store, read sequencer, fold and output register.
module gbu_back #(
	parameter int MAX_RUN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbu_pkg::gbu_cfg_t cfg,
	input  gbu_pkg::gbu_wr_t  wr,
	input  gbu_pkg::gbu_cmd_t head,
	input  logic              head_valid,
	output logic              pop,
	output logic              run_done,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_run_last,
	output logic              out_grid_done
);
	import gbu_pkg::*;

	localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

	logic [7:0]    store_q [MAX_RUN];
	logic [5:0]    k_q;
	logic          valid_s1;
	logic          use_mem_s1;
	logic          invert_s1;
	logic [7:0]    byte_s1;
	logic [7:0]    rd_data_s1;
	logic          last_s1;
	logic          done_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_done_q;

	logic          is_run;
	logic          step_last;
	logic [6:0]    rd_idx;
	logic          move;
	logic          issue;
	logic [7:0]    raw;
	logic [7:0]    unpacked;

	// Read sequencer over the head command
	assign is_run    = (head.kind != KIND_PASS);
	assign step_last = !is_run || ({1'b0, k_q} == head.count - 7'd1);
	assign rd_idx    = (head.kind == KIND_REV) ? (head.count - 7'd1 - {1'b0, k_q})
	                                           : {1'b0, k_q};
	assign move      = valid_s1 && (!out_valid_q || out_ready);
	assign issue     = head_valid && (!valid_s1 || move);
	assign pop       = issue && step_last;
	assign run_done  = pop && is_run;

	// Run store: written by the front, read by the sequencer
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr[AW-1:0]] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= store_q[rd_idx[AW-1:0]];
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			use_mem_s1 <= is_run;
			invert_s1  <= (head.kind == KIND_REV);
			byte_s1    <= head.data;
			last_s1    <= step_last;
			done_s1    <= step_last && head.last_grid;
		end
	end

	// Sequencer index and read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= step_last ? 6'd0 : k_q + 6'd1;
			end
			valid_s1 <= issue || (valid_s1 && !move);
		end
	end

	// Unpack; the fold is applied in the output register
	assign raw      = use_mem_s1 ? rd_data_s1 : byte_s1;
	assign unpacked = invert_s1 ? ~raw : raw;

	// Output register
	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= (cfg.fold_enable && unpacked == cfg.fold_from) ? cfg.fold_to
			                                                             : unpacked;
			out_last_q <= last_s1;
			out_done_q <= done_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign out_run_last  = out_last_q;
	assign out_grid_done = out_done_q;

	// A finished run always belongs to a run command at the head
	a_run_done_head: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |-> (head_valid && (head.kind == KIND_REV || head.kind == KIND_FWD)))
		else $error("run release without a run command");

	// The read index stays inside the run
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && is_run) |-> ({1'b0, k_q} < head.count))
		else $error("run read index out of range");

	// A read result waits until the output register takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move) |=> valid_s1)
		else $error("read stage beat lost");

endmodule

// File: hw/rtl/grid_byte_unpacker_top.sv
// Top level of the grid byte unpacker: config registers, front, queue, back.
//
// Channel  Dir  Beat fields (low bit up)
// s_axis   in   tdata[7:0] in_byte, tlast grid_end
// m_axis   out  tdata[7:0] out_byte, tuser run_last, tlast grid_done
// cfg      in   cfg_index register number, cfg_data value
//
// Pass through and invert modes take one byte per cycle when the output does not
// stall; a byte passes the queue entry, the read stage and the output register.
// Mode 2 fills a run of L bytes at one per cycle, then holds the input while the
// back reads the run out of the store, one byte per cycle when the output does not
// stall. Reset clears control state only; the run store is not cleared. Either
// side may stall at any cycle; the command queue absorbs up to four beats.
module grid_byte_unpacker_top #(
	parameter int MAX_RUN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] run_last
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [gbu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import gbu_pkg::*;

	gbu_cfg_t cfg_q;
	logic     cfg_write;
	logic     cfg_clear;
	logic     q_push;
	gbu_cmd_t q_cmd;
	logic     q_full;
	gbu_cmd_t head;
	logic     head_valid;
	logic     pop;
	logic     run_done;
	gbu_wr_t  wr;

	// Config write port, always ready
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_clear = cfg_write && (cfg_index == REG_PACK_MODE || cfg_index == REG_RUN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PACK_MODE:   cfg_q.pack_mode   <= cfg_data[1:0];
				REG_RUN_LENGTH:  cfg_q.run_length  <= cfg_data[6:0];
				REG_FOLD_ENABLE: cfg_q.fold_enable <= cfg_data[0];
				REG_FOLD_FROM:   cfg_q.fold_from   <= cfg_data;
				REG_FOLD_TO:     cfg_q.fold_to     <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	gbu_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_clear (cfg_clear),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.q_push    (q_push),
		.q_cmd     (q_cmd),
		.q_full    (q_full),
		.wr        (wr),
		.run_done  (run_done)
	);

	gbu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	gbu_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.wr            (wr),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.run_done      (run_done),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.out_run_last  (m_axis_tuser),
		.out_grid_done (m_axis_tlast)
	);

endmodule
